FILE: rtl/smmv_pkg.sv
// Shared constants and types of the sample statistics unit.
package smmv_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int SAMPLES_MAX = 65536;

	localparam int COUNT_W = 17;
	localparam int SUM_W   = 32;
	localparam int SQSUM_W = 47;
	localparam int MEAN_W  = 32;
	localparam int VAR_W   = 47;

	// n*sumsq - sum^2 always fits here; every product of the shared multiplier does too
	localparam int DIFF_W  = 63;
	localparam int PROD_W  = DIFF_W;
	localparam int MUL_W   = 32;
	localparam int LO_W    = 24;

	localparam int DVD_W   = DIFF_W + FRAC_BITS;
	localparam int DVS_W   = 2 * COUNT_W - 1;
	localparam int DCNT_W  = $clog2(DVD_W);

	localparam int TDATA_IN_W  = 16;
	localparam int TDATA_OUT_W = 128;

	typedef struct packed {
		logic [COUNT_W-1:0]        count;
		logic signed [SUM_W-1:0]   sum;
		logic [SQSUM_W-1:0]        sqsum;
		logic signed [SAMPLE_BITS-1:0] min;
		logic signed [SAMPLE_BITS-1:0] max;
		logic                      dropped;
	} stats_t;

	typedef struct packed {
		logic done;
		logic rem_nz;
	} div_status_t;

endpackage

FILE: rtl/smmv_accum.sv
// Running count, sum, sum of squares, minimum and maximum of one sample set.
module smmv_accum (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  upd,
	input  logic                                  clr,
	input  logic signed [smmv_pkg::SAMPLE_BITS-1:0] sample,
	output smmv_pkg::stats_t                      stats
);

	smmv_pkg::stats_t stats_q;
	logic signed [2*smmv_pkg::SAMPLE_BITS-1:0] sq;
	logic                                      room;

	assign sq    = sample * sample;
	assign room  = stats_q.count != smmv_pkg::COUNT_W'(smmv_pkg::SAMPLES_MAX);
	assign stats = stats_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q.count   <= '0;
			stats_q.sum     <= '0;
			stats_q.sqsum   <= '0;
			stats_q.min     <= {1'b0, {(smmv_pkg::SAMPLE_BITS-1){1'b1}}};
			stats_q.max     <= {1'b1, {(smmv_pkg::SAMPLE_BITS-1){1'b0}}};
			stats_q.dropped <= 1'b0;
		end else if (clr) begin
			stats_q.count   <= '0;
			stats_q.sum     <= '0;
			stats_q.sqsum   <= '0;
			stats_q.min     <= {1'b0, {(smmv_pkg::SAMPLE_BITS-1){1'b1}}};
			stats_q.max     <= {1'b1, {(smmv_pkg::SAMPLE_BITS-1){1'b0}}};
			stats_q.dropped <= 1'b0;
		end else if (upd) begin
			if (room) begin
				stats_q.count <= stats_q.count + smmv_pkg::COUNT_W'(1);
				stats_q.sum   <= stats_q.sum + smmv_pkg::SUM_W'(sample);
				stats_q.sqsum <= stats_q.sqsum + smmv_pkg::SQSUM_W'($unsigned(sq));
				if (sample < stats_q.min) begin
					stats_q.min <= sample;
				end
				if (sample > stats_q.max) begin
					stats_q.max <= sample;
				end
			end else begin
				// set is full: drop the sample, remember it
				stats_q.dropped <= 1'b1;
			end
		end
	end

endmodule

FILE: rtl/smmv_divider.sv
// Restoring divider, one quotient bit per cycle, shared by mean and variance.
module smmv_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [smmv_pkg::DVD_W-1:0]   dividend,
	input  logic [smmv_pkg::DVS_W-1:0]   divisor,
	output logic [smmv_pkg::DVD_W-1:0]   quotient,
	output smmv_pkg::div_status_t        status
);

	logic [smmv_pkg::DVD_W-1:0]  work_q;
	logic [smmv_pkg::DVS_W-1:0]  rem_q;
	logic [smmv_pkg::DVS_W-1:0]  dvs_q;
	logic [smmv_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [smmv_pkg::DVS_W:0]    shifted;
	logic [smmv_pkg::DVS_W:0]    diff;
	logic                        fits;

	assign shifted = {rem_q, work_q[smmv_pkg::DVD_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};

	assign quotient      = work_q;
	assign status.done   = done_q;
	assign status.rem_nz = rem_q != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == smmv_pkg::DCNT_W'(smmv_pkg::DVD_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + smmv_pkg::DCNT_W'(1);
				if (cnt_q == smmv_pkg::DCNT_W'(smmv_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// dividend shifts out at the top while quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[smmv_pkg::DVD_W-2:0], fits};
			rem_q  <= fits ? diff[smmv_pkg::DVS_W-1:0] : shifted[smmv_pkg::DVS_W-1:0];
		end
	end

endmodule

FILE: rtl/sample_min_max_mean_variance_unit.sv
// Top level: sample statistics with a multiply/divide sequencer and result register.
// Throughput: one sample per cycle while a set is gathered.
// A last sample holds s_tready low through five multiply/accumulate steps, then two
// 79-step restoring divisions (mean, then variance), then the load.
// The result shows on m_tvalid with the load, which waits while an earlier result is stalled.
// Reset (arst_n low) clears the running statistics and drops any pending result.
module sample_min_max_mean_variance_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [smmv_pkg::TDATA_IN_W-1:0]     s_tdata,  // [15:0] sample_value
	input  logic                                s_tlast,  // last_sample
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [smmv_pkg::TDATA_OUT_W-1:0]    m_tdata,  // sample_count, minimum, maximum,
	                                                      // mean_q16, variance_q16
	output logic                                m_tuser   // overflow
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_NN, ST_SQ, ST_LO, ST_HI, ST_ADD,
		ST_MEAN_GO, ST_MEAN_WAIT, ST_VAR_GO, ST_VAR_WAIT, ST_OUT
	} state_t;

	state_t                              state_q;
	smmv_pkg::stats_t                    stats;
	smmv_pkg::div_status_t               div_st;
	logic [smmv_pkg::DVD_W-1:0]          quotient;
	logic [smmv_pkg::DVD_W-1:0]          dividend;
	logic [smmv_pkg::DVS_W-1:0]          divisor;
	logic                                accept;
	logic                                clr;
	logic                                div_start;
	logic [smmv_pkg::SUM_W-1:0]          mag;
	logic [smmv_pkg::MUL_W-1:0]          mul_a;
	logic [smmv_pkg::MUL_W-1:0]          mul_b;
	logic [2*smmv_pkg::MUL_W-1:0]        prod;
	logic [smmv_pkg::PROD_W-1:0]         prod_q;
	logic [smmv_pkg::DIFF_W-1:0]         acc_q;
	logic [smmv_pkg::DVS_W-1:0]          nn_q;
	logic [smmv_pkg::MEAN_W-1:0]         q_mean;
	logic [smmv_pkg::MEAN_W-1:0]         mean_q;
	logic [smmv_pkg::VAR_W-1:0]          var_q;
	logic                                out_valid_q;
	logic [smmv_pkg::TDATA_OUT_W-1:0]    out_data_q;
	logic                                out_user_q;

	assign s_tready = state_q == ST_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign clr      = (state_q == ST_OUT) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	smmv_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (accept),
		.clr    (clr),
		.sample (s_tdata[smmv_pkg::SAMPLE_BITS-1:0]),
		.stats  (stats)
	);

	assign mag = stats.sum[smmv_pkg::SUM_W-1] ? smmv_pkg::SUM_W'(-stats.sum)
	                                          : smmv_pkg::SUM_W'(stats.sum);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = smmv_pkg::MUL_W'(stats.count);
		mul_b = smmv_pkg::MUL_W'(stats.count);
		case (state_q)
			ST_SQ: begin
				mul_a = mag;
				mul_b = mag;
			end
			ST_LO: begin
				mul_b = smmv_pkg::MUL_W'(stats.sqsum[smmv_pkg::LO_W-1:0]);
			end
			ST_HI: begin
				mul_b = smmv_pkg::MUL_W'(stats.sqsum[smmv_pkg::SQSUM_W-1:smmv_pkg::LO_W]);
			end
			default: begin
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign div_start = (state_q == ST_MEAN_GO) || (state_q == ST_VAR_GO);
	assign dividend  = (state_q == ST_MEAN_GO)
		? smmv_pkg::DVD_W'({mag, {smmv_pkg::FRAC_BITS{1'b0}}})
		: {acc_q, {smmv_pkg::FRAC_BITS{1'b0}}};
	assign divisor   = (state_q == ST_MEAN_GO) ? smmv_pkg::DVS_W'(stats.count) : nn_q;
	assign q_mean    = quotient[smmv_pkg::MEAN_W-1:0];

	smmv_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient),
		.status   (div_st)
	);

	always_ff @(posedge clk) begin
		prod_q <= prod[smmv_pkg::PROD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_user_q  <= 1'b0;
			nn_q        <= '0;
			acc_q       <= '0;
			mean_q      <= '0;
			var_q       <= '0;
		end else begin
			if (clr) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tlast) begin
						state_q <= ST_NN;
					end
				end
				ST_NN: begin
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					nn_q    <= prod_q[smmv_pkg::DVS_W-1:0];
					state_q <= ST_LO;
				end
				ST_LO: begin
					acc_q   <= '0 - prod_q;
					state_q <= ST_HI;
				end
				ST_HI: begin
					acc_q   <= acc_q + prod_q;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					acc_q   <= acc_q + (prod_q << smmv_pkg::LO_W);
					state_q <= ST_MEAN_GO;
				end
				ST_MEAN_GO: begin
					state_q <= ST_MEAN_WAIT;
				end
				ST_MEAN_WAIT: begin
					if (div_st.done) begin
						// floor toward minus infinity for a negative sum
						mean_q  <= stats.sum[smmv_pkg::SUM_W-1]
							? '0 - (q_mean + smmv_pkg::MEAN_W'(div_st.rem_nz))
							: q_mean;
						state_q <= ST_VAR_GO;
					end
				end
				ST_VAR_GO: begin
					state_q <= ST_VAR_WAIT;
				end
				ST_VAR_WAIT: begin
					if (div_st.done) begin
						var_q   <= quotient[smmv_pkg::VAR_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the previous result has been taken
					if (clr) begin
						out_data_q <= {var_q, mean_q, stats.max, stats.min, stats.count};
						out_user_q <= stats.dropped;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/smmv_checker.sv
// Port checker for the sample statistics unit, bound to the top level.
module smmv_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             s_tlast,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [smmv_pkg::TDATA_OUT_W-1:0] m_tdata,
	input logic                             m_tuser
);

	// a last sample starts the result computation: no request taken next cycle
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("request accepted right after a last sample");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed or vanished");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16:0] != 17'd0) && (m_tdata[16:0] <= 17'd65536))
		else $error("result count out of range");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[32:17]) <= $signed(m_tdata[48:33]))
		else $error("result minimum above maximum");

	a_mean_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[80:49]) >= $signed({m_tdata[32:17], 16'h0000}))
			&& ($signed(m_tdata[80:49]) <= $signed({m_tdata[48:33], 16'h0000})))
		else $error("result mean outside minimum and maximum");

endmodule

bind sample_min_max_mean_variance_unit smmv_checker u_smmv_checker (.*);

FILE: sim/sample_min_max_mean_variance_unit_tb.sv
// Self-checking testbench of the sample statistics unit against predicted set summaries.
module sample_min_max_mean_variance_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int TAIL_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 1900;

	localparam int MIN_LSB  = smmv_pkg::COUNT_W;
	localparam int MAX_LSB  = MIN_LSB + smmv_pkg::SAMPLE_BITS;
	localparam int MEAN_LSB = MAX_LSB + smmv_pkg::SAMPLE_BITS;
	localparam int VAR_LSB  = MEAN_LSB + smmv_pkg::MEAN_W;

	typedef struct {
		logic [smmv_pkg::COUNT_W-1:0]            count;
		logic signed [smmv_pkg::SAMPLE_BITS-1:0] smallest;
		logic signed [smmv_pkg::SAMPLE_BITS-1:0] largest;
		logic signed [smmv_pkg::MEAN_W-1:0]      mean;
		logic [smmv_pkg::VAR_W-1:0]              variance;
		logic                                    dropped;
	} set_stats_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [smmv_pkg::TDATA_IN_W-1:0] s_tdata;   // [15:0] sample_value
	logic s_tlast;                              // last_sample
	logic m_tvalid;
	logic m_tready;
	logic [smmv_pkg::TDATA_OUT_W-1:0] m_tdata;  // sample_count, minimum, maximum, mean_q16,
	                                            // variance_q16
	logic m_tuser;                              // overflow

	set_stats_t pending_stats[$];
	int  mismatches = 0;
	int  cycle_count = 0;
	int  random_items = 0;
	bit  idle_on = 1'b1;

	// running statistics of the set being gathered
	int     acc_count;
	longint acc_sum;
	longint acc_sqsum;
	int     acc_min;
	int     acc_max;
	bit     acc_dropped;

	sample_min_max_mean_variance_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_stats.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic void clear_set();
		acc_count   = 0;
		acc_sum     = 0;
		acc_sqsum   = 0;
		acc_min     = 32767;
		acc_max     = -32768;
		acc_dropped = 1'b0;
	endfunction

	function automatic void gather_sample(input logic signed [smmv_pkg::SAMPLE_BITS-1:0] value,
			input bit last);
		int v;
		longint num;
		longint q;
		logic [63:0] spread;
		logic [95:0] scaled;
		logic [95:0] nn;
		logic [95:0] qv;
		set_stats_t st;
		v = value;
		if (acc_count < smmv_pkg::SAMPLES_MAX) begin
			acc_count++;
			acc_sum   += v;
			acc_sqsum += longint'(v) * longint'(v);
			if (v < acc_min) acc_min = v;
			if (v > acc_max) acc_max = v;
		end else begin
			acc_dropped = 1'b1;
		end
		if (!last) return;
		st.count    = smmv_pkg::COUNT_W'(acc_count);
		st.smallest = smmv_pkg::SAMPLE_BITS'(acc_min);
		st.largest  = smmv_pkg::SAMPLE_BITS'(acc_max);
		st.dropped  = acc_dropped;
		st.mean     = '0;
		st.variance = '0;
		if (acc_count != 0) begin
			// floor toward minus infinity
			num = acc_sum * 65536;
			q = num / acc_count;
			if (num < 0 && (num % acc_count) != 0) q = q - 1;
			st.mean = q[smmv_pkg::MEAN_W-1:0];
			spread = longint'(acc_count) * acc_sqsum - acc_sum * acc_sum;
			scaled = {32'b0, spread} << smmv_pkg::FRAC_BITS;
			nn = {32'b0, 64'(longint'(acc_count) * longint'(acc_count))};
			qv = scaled / nn;
			st.variance = qv[smmv_pkg::VAR_W-1:0];
		end
		pending_stats.push_back(st);
		clear_set();
	endfunction

	task automatic send_sample(input logic signed [smmv_pkg::SAMPLE_BITS-1:0] value,
			input bit last);
		int gap;
		gap = idle_on ? int'($urandom_range(0, 5)) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		gather_sample(value, last);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_stats.size() != 0);
	endtask

	function automatic logic signed [smmv_pkg::SAMPLE_BITS-1:0] pick_value();
		int sel;
		sel = $urandom_range(0, 7);
		case (sel)
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return smmv_pkg::SAMPLE_BITS'($urandom_range(0, 15) - 8);
			default: return smmv_pkg::SAMPLE_BITS'($urandom);
		endcase
	endfunction

	task automatic test_single_sample_sets();
		send_sample(-16'sd32768, 1'b1);
		send_sample(16'sd32767, 1'b1);
		send_sample(16'sd0, 1'b1);
		send_sample(-16'sd1, 1'b1);
	endtask

	task automatic test_mean_floor_and_spread();
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd0, 1'b1);
		send_sample(-16'sd1, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd0, 1'b1);
		send_sample(16'sd1, 1'b0);
		send_sample(16'sd2, 1'b1);
		send_sample(-16'sd32768, 1'b0);
		send_sample(16'sd32767, 1'b1);
		send_sample(16'sd5, 1'b0);
		send_sample(16'sd5, 1'b0);
		send_sample(-16'sd7, 1'b0);
		send_sample(16'sd3, 1'b1);
	endtask

	task automatic test_random_sets();
		int len;
		int k;
		while (random_items < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 7) != 0);
			len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(17, 300))
			                                  : int'($urandom_range(1, 16));
			for (k = 0; k < len; k++) begin
				send_sample(pick_value(), k == len - 1);
				random_items++;
			end
			if ($urandom_range(0, 19) == 0) wait_for_results();
		end
		idle_on = 1'b1;
	endtask

	initial begin : result_monitor
		int stall;
		set_stats_t want;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_on ? int'($urandom_range(0, 5)) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_stats.size() == 0) begin
				report_mismatch($sformatf("unexpected result, count %0d",
					m_tdata[smmv_pkg::COUNT_W-1:0]));
			end else begin
				want = pending_stats.pop_front();
				if (m_tdata[smmv_pkg::COUNT_W-1:0] !== want.count)
					report_mismatch($sformatf("sample_count got %0d expected %0d",
						m_tdata[smmv_pkg::COUNT_W-1:0], want.count));
				if ($signed(m_tdata[MIN_LSB +: smmv_pkg::SAMPLE_BITS]) !== want.smallest)
					report_mismatch($sformatf("minimum got %0d expected %0d",
						$signed(m_tdata[MIN_LSB +: smmv_pkg::SAMPLE_BITS]), want.smallest));
				if ($signed(m_tdata[MAX_LSB +: smmv_pkg::SAMPLE_BITS]) !== want.largest)
					report_mismatch($sformatf("maximum got %0d expected %0d",
						$signed(m_tdata[MAX_LSB +: smmv_pkg::SAMPLE_BITS]), want.largest));
				if ($signed(m_tdata[MEAN_LSB +: smmv_pkg::MEAN_W]) !== want.mean)
					report_mismatch($sformatf("mean_q16 got %0d expected %0d",
						$signed(m_tdata[MEAN_LSB +: smmv_pkg::MEAN_W]), want.mean));
				if (m_tdata[VAR_LSB +: smmv_pkg::VAR_W] !== want.variance)
					report_mismatch($sformatf("variance_q16 got %0d expected %0d",
						m_tdata[VAR_LSB +: smmv_pkg::VAR_W], want.variance));
				if (m_tuser !== want.dropped)
					report_mismatch($sformatf("overflow got %0b expected %0b",
						m_tuser, want.dropped));
			end
		end
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		clear_set();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_sample_sets();
		test_mean_floor_and_spread();
		wait_for_results();
		test_random_sets();

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_stats.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
